@@ rtl/core/rvf_pkg.sv @@
`default_nettype none

package rvf_pkg;

  // Largest frame dimension the counters cover.
  localparam int MaxDim = 4096;
  localparam int DimW   = 13;   // width of a dimension register
  localparam int CntW   = 12;   // width of the row and column counters
  localparam int DistW  = 25;   // width of a squared distance
  localparam int RadW   = 24;   // width of a squared radius
  localparam int ScaleW = 32;   // width of the reciprocal scale
  localparam int ProdW  = RadW + ScaleW;
  localparam int FactW  = 17;   // Q1.16 factor, 65536 means one
  localparam int ChanW  = 8;
  localparam int PixW   = 3 * ChanW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Queue between the front and the back.
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInnerSq     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOuterSq     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFadeScale   = 3'd4;

  // Reset values of the registers.
  localparam logic [DimW-1:0] ResetWidth  = 13'd640;
  localparam logic [DimW-1:0] ResetHeight = 13'd480;

  // Unity and zero gain in Q1.16.
  localparam logic [FactW-1:0] FactorOne  = 17'h10000;
  localparam logic [FactW-1:0] FactorZero = 17'h00000;

  // How a pixel is treated, decided by its distance from the center.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_FADE  = 2'd1,
    KIND_BLACK = 2'd2
  } kind_t;

  // Configuration as seen by the front and the back.
  typedef struct packed {
    logic [DimW-1:0]   frame_width;
    logic [DimW-1:0]   frame_height;
    logic [RadW-1:0]   inner_sq_radius;
    logic [RadW-1:0]   outer_sq_radius;
    logic [ScaleW-1:0] fade_scale;
  } cfg_t;

  // One classified pixel in the queue.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
    kind_t            kind;
    logic [RadW-1:0]  delta;
  } item_t;

  // Clamp a dimension register into one to MaxDim.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Absolute difference of two counter values.
  function automatic logic [CntW-1:0] abs_diff(input logic [CntW-1:0] a,
                                               input logic [CntW-1:0] b);
    logic [CntW-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rvf_front.sv @@
`default_nettype none

module rvf_front (
  input  wire                          clk,
  input  wire                          rst,
  input  rvf_pkg::cfg_t                cfg,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [rvf_pkg::PixW-1:0]     s_tdata,
  input  wire                          q_full,
  output logic                         q_push,
  output rvf_pkg::item_t               q_item
);
  import rvf_pkg::*;

  logic [DimW-1:0] width_c;
  logic [DimW-1:0] height_c;
  logic [CntW-1:0] center_x;
  logic [CntW-1:0] center_y;
  logic [CntW-1:0] column_count;
  logic [CntW-1:0] row_count;
  logic            col_end;
  logic            row_end;
  logic            accept;

  logic             s1_valid;
  logic [PixW-1:0]  s1_pix;
  logic             s1_last;
  logic [CntW-1:0]  s1_cdiff;
  logic [CntW-1:0]  s1_rdiff;

  logic             s2_valid;
  logic [PixW-1:0]  s2_pix;
  logic             s2_last;
  logic [DistW-1:0] s2_dist;

  logic s1_free;
  logic s2_free;
  logic [2*CntW-1:0] csq;
  logic [2*CntW-1:0] rsq;

  // Frame geometry from the clamped dimensions.
  assign width_c  = clamp_dim(cfg.frame_width);
  assign height_c = clamp_dim(cfg.frame_height);
  assign center_x = width_c[DimW-1:1];
  assign center_y = height_c[DimW-1:1];
  assign col_end  = ({1'b0, column_count} + DimW'(1)) >= width_c;
  assign row_end  = ({1'b0, row_count} + DimW'(1)) >= height_c;

  // Ready chain of the two front stages.
  assign q_push   = s2_valid && !q_full;
  assign s2_free  = !s2_valid || q_push;
  assign s1_free  = !s1_valid || s2_free;
  assign s_tready = s1_free;
  assign accept   = s_tvalid && s1_free;

  // Position counters advance on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + CntW'(1);
      end else begin
        column_count <= column_count + CntW'(1);
      end
    end
  end

  // Stage one: pixel, frame end and distances along each axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= s_tdata;
      s1_last  <= col_end && row_end;
      s1_cdiff <= abs_diff(center_x, column_count);
      s1_rdiff <= abs_diff(center_y, row_count);
    end
  end

  // Stage two: squared distance from the center.
  assign csq = s1_cdiff * s1_cdiff;
  assign rsq = s1_rdiff * s1_rdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_pix  <= s1_pix;
      s2_last <= s1_last;
      s2_dist <= DistW'(csq) + DistW'(rsq);
    end
  end

  // Classify against the two radii on the way into the queue.
  always_comb begin
    q_item.red       = s2_pix[ChanW-1:0];
    q_item.green     = s2_pix[2*ChanW-1:ChanW];
    q_item.blue      = s2_pix[3*ChanW-1:2*ChanW];
    q_item.frame_end = s2_last;
    q_item.delta     = s2_dist[RadW-1:0] - cfg.inner_sq_radius;
    if (s2_dist <= {1'b0, cfg.inner_sq_radius}) begin
      q_item.kind = KIND_PASS;
    end else if (s2_dist < {1'b0, cfg.outer_sq_radius}) begin
      q_item.kind = KIND_FADE;
    end else begin
      q_item.kind = KIND_BLACK;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rvf_queue.sv @@
`default_nettype none

module rvf_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  rvf_pkg::item_t       push_item,
  output logic                 full,
  input  wire                  pop,
  output rvf_pkg::item_t       pop_item,
  output logic                 empty
);
  import rvf_pkg::*;

  item_t             slots [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QCntW-1:0]  fill;

  assign full     = fill == QCntW'(QDepth);
  assign empty    = fill == '0;
  assign pop_item = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAddrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAddrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCntW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCntW'(1);
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rvf_back.sv @@
`default_nettype none

module rvf_back (
  input  wire                          clk,
  input  wire                          rst,
  input  rvf_pkg::cfg_t                cfg,
  input  wire                          q_empty,
  input  rvf_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [rvf_pkg::PixW-1:0]     m_tdata,
  output logic                         m_tlast
);
  import rvf_pkg::*;

  logic              b1_valid;
  item_t             b1_item;
  logic [ProdW-1:0]  b1_prod;

  logic              b2_valid;
  logic [PixW-1:0]   b2_pix;
  logic              b2_last;
  logic [FactW-1:0]  b2_factor;

  logic              b1_free;
  logic              b2_free;
  logic              out_free;
  logic [FactW-1:0]  factor;
  logic [ChanW+FactW-1:0] red_p;
  logic [ChanW+FactW-1:0] green_p;
  logic [ChanW+FactW-1:0] blue_p;

  // Ready chain of the back stages.
  assign out_free = !m_tvalid || m_tready;
  assign b2_free  = !b2_valid || out_free;
  assign b1_free  = !b1_valid || b2_free;
  assign q_pop    = !q_empty && b1_free;

  // Stage one: scale the distance past the inner radius.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_free) begin
      b1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_item <= q_item;
      b1_prod <= q_item.delta * cfg.fade_scale;
    end
  end

  // Gain for the pixel: one inside, zero outside, one minus the fade between.
  always_comb begin
    case (b1_item.kind)
      KIND_PASS: begin
        factor = FactorOne;
      end
      KIND_FADE: begin
        if (b1_prod[ProdW-1:32] != '0) begin
          factor = FactorZero;
        end else begin
          factor = FactorOne - {1'b0, b1_prod[31:16]};
        end
      end
      default: begin
        factor = FactorZero;
      end
    endcase
  end

  // Stage two: hold the gain with the pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (b2_free) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_free && b1_valid) begin
      b2_pix    <= {b1_item.blue, b1_item.green, b1_item.red};
      b2_last   <= b1_item.frame_end;
      b2_factor <= factor;
    end
  end

  // Apply the gain to each channel and keep the integer part.
  assign red_p   = b2_pix[ChanW-1:0] * b2_factor;
  assign green_p = b2_pix[2*ChanW-1:ChanW] * b2_factor;
  assign blue_p  = b2_pix[3*ChanW-1:2*ChanW] * b2_factor;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b2_valid) begin
      m_tdata <= {blue_p[23:16], green_p[23:16], red_p[23:16]};
      m_tlast <= b2_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/radial_vignette_fade.sv @@
// Round vignette over a raster-order RGB pixel stream.
// Slave channel s_*: one pixel per request, red in tdata[7:0], green in
// tdata[15:8], blue in tdata[23:16]. Master channel m_*: the faded pixel in
// the same layout, with tlast high on the last pixel of a frame.
// Configuration port: cfg_we writes cfg_data into the register named by
// cfg_index (0 width, 1 height, 2 inner squared radius, 3 outer squared
// radius, 4 fade scale). Write it only while no pixel is in flight.
// Throughput is one pixel per cycle while the receiver takes every pixel.
// A pixel passes two front stages (axis distances, then the squared distance and
// the radius compare), a slot of the four-entry queue and two back stages (the
// 24 x 32 scale multiply, then the channel gain multiply) to the output register.
// Reset clears the row and column counters, empties the pipeline and loads
// the register defaults (640 by 480, radii and scale zero).
// When the receiver stalls, the output register holds its pixel; the back
// stages and the queue fill, then the front stops taking input.
`default_nettype none

module radial_vignette_fade (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [rvf_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire  [rvf_pkg::CfgDataW-1:0]     cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [rvf_pkg::PixW-1:0]         s_tdata,   // red_in, green_in, blue_in
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [rvf_pkg::PixW-1:0]         m_tdata,   // red_out, green_out, blue_out
  output logic                             m_tlast    // frame_end
);
  import rvf_pkg::*;

  cfg_t  cfg;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_in;
  item_t q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= ResetWidth;
      cfg.frame_height    <= ResetHeight;
      cfg.inner_sq_radius <= '0;
      cfg.outer_sq_radius <= '0;
      cfg.fade_scale      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFrameWidth:  cfg.frame_width     <= cfg_data[DimW-1:0];
        RegFrameHeight: cfg.frame_height    <= cfg_data[DimW-1:0];
        RegInnerSq:     cfg.inner_sq_radius <= cfg_data[RadW-1:0];
        RegOuterSq:     cfg.outer_sq_radius <= cfg_data[RadW-1:0];
        RegFadeScale:   cfg.fade_scale      <= cfg_data[ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: position tracking and classification.
  rvf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // Queue between front and back.
  rvf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  // Back: fade arithmetic and output register.
  rvf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/radial_vignette_fade_tb.sv @@
`timescale 1ns / 1ps

module radial_vignette_fade_tb;
  import rvf_pkg::*;

  localparam int HoldCycles   = 80;
  localparam int SettleCycles = 10;
  localparam int TotalPixels  = 1750;

  // One faded pixel as it should leave the block.
  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
  } faded_px_t;

  // Scoreboard: mirrors the vignette registers and the raster position, and
  // keeps the faded pixels that are still due on the output.
  class fade_scoreboard;
    logic [DimW-1:0]   width_q;
    logic [DimW-1:0]   height_q;
    logic [RadW-1:0]   inner_q;
    logic [RadW-1:0]   outer_q;
    logic [ScaleW-1:0] scale_q;
    int unsigned       col_pos;
    int unsigned       row_pos;
    faded_px_t         faded_q[$];
    int unsigned       errors;
    int unsigned       n_results;
    int unsigned       n_frames;
    int unsigned       n_pass;
    int unsigned       n_fade;
    int unsigned       n_black;

    function new();
      width_q  = ResetWidth;
      height_q = ResetHeight;
      inner_q  = '0;
      outer_q  = '0;
      scale_q  = '0;
      col_pos  = 0;
      row_pos  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegFrameWidth:  width_q  = val[DimW-1:0];
        RegFrameHeight: height_q = val[DimW-1:0];
        RegInnerSq:     inner_q  = val[RadW-1:0];
        RegOuterSq:     outer_q  = val[RadW-1:0];
        RegFadeScale:   scale_q  = val[ScaleW-1:0];
        default: ;
      endcase
    endfunction

    // A zero dimension counts as one, anything above the counter range as
    // the largest frame.
    function int unsigned eff_dim(logic [DimW-1:0] v);
      if (v == '0) return 1;
      if (v > MaxDim) return MaxDim;
      return 32'(v);
    endfunction

    // Work out the faded pixel for one accepted request and advance the
    // raster position.
    function void predict_pixel(logic [PixW-1:0] px);
      int unsigned     w, h, cx, cy, dx, dy, sq_dist;
      longint unsigned fade, factor;
      kind_t           kind;
      logic [PixW-1:0] faded;
      bit              col_end, row_end;
      faded_px_t       e;
      w  = eff_dim(width_q);
      h  = eff_dim(height_q);
      cx = w / 2;
      cy = h / 2;
      dx = (cx > col_pos) ? cx - col_pos : col_pos - cx;
      dy = (cy > row_pos) ? cy - row_pos : row_pos - cy;
      sq_dist = dx * dx + dy * dy;

      // Classify against the two radii; unity gain passes the pixel as is.
      factor = 65536;
      if (sq_dist <= inner_q) begin
        kind = KIND_PASS;
      end else if (sq_dist < outer_q) begin
        kind = KIND_FADE;
        fade = (64'(sq_dist - inner_q) * 64'(scale_q)) >> 16;
        factor = (fade >= 65536) ? 0 : 65536 - fade;
      end else begin
        kind = KIND_BLACK;
        factor = 0;
      end
      case (kind)
        KIND_PASS: n_pass++;
        KIND_FADE: n_fade++;
        default:   n_black++;
      endcase
      for (int i = 0; i < 3; i++) begin
        faded[ChanW*i +: ChanW] = ChanW'((64'(px[ChanW*i +: ChanW]) * factor) >> 16);
      end

      // A counter at or past the last index ends the row or the frame.
      col_end = (col_pos + 1 >= w);
      row_end = (row_pos + 1 >= h);
      e.red       = faded[ChanW-1:0];
      e.green     = faded[2*ChanW-1:ChanW];
      e.blue      = faded[3*ChanW-1:2*ChanW];
      e.frame_end = col_end && row_end;
      if (e.frame_end) n_frames++;
      faded_q.push_back(e);
      if (col_end) begin
        col_pos = 0;
        row_pos = row_end ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one output request with the oldest faded pixel still due.
    task check_faded(logic [PixW-1:0] px, logic last);
      faded_px_t e;
      n_results++;
      if (faded_q.size() == 0) begin
        report($sformatf("output %0d: pixel %06h with nothing due", n_results, px));
        return;
      end
      e = faded_q.pop_front();
      if (px[ChanW-1:0] !== e.red)
        report($sformatf("output %0d: red %02h, want %02h", n_results, px[ChanW-1:0], e.red));
      if (px[2*ChanW-1:ChanW] !== e.green)
        report($sformatf("output %0d: green %02h, want %02h", n_results,
                         px[2*ChanW-1:ChanW], e.green));
      if (px[3*ChanW-1:2*ChanW] !== e.blue)
        report($sformatf("output %0d: blue %02h, want %02h", n_results,
                         px[3*ChanW-1:2*ChanW], e.blue));
      if (last !== e.frame_end)
        report($sformatf("output %0d: tlast %b, want %b", n_results, last, e.frame_end));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [PixW-1:0]     s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [PixW-1:0]     m_tdata;
  logic                m_tlast;

  fade_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    n_configs  = 0;

  radial_vignette_fade DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Both request channels are observed here, with values from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.predict_pixel(s_tdata);
      if (m_tvalid && m_tready) sb.check_faded(m_tdata, m_tlast);
    end
  end

  // Output side: random back-pressure, a quiet window, and two long hold-offs
  // that fill the pipeline and stall the input.
  initial begin : receiver
    int unsigned holds;
    holds = 0;
    forever begin
      @(posedge clk);
      if ((holds == 0 && sb.n_results >= 150) || (holds == 1 && sb.n_results >= 1300)) begin
        holds++;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (sb.n_results >= 800 && sb.n_results < 1100) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                           input logic [RadW-1:0] inner, input logic [RadW-1:0] outer,
                           input logic [ScaleW-1:0] scale);
    write_reg(RegFrameWidth, CfgDataW'(w));
    write_reg(RegFrameHeight, CfgDataW'(h));
    write_reg(RegInnerSq, CfgDataW'(inner));
    write_reg(RegOuterSq, CfgDataW'(outer));
    write_reg(RegFadeScale, CfgDataW'(scale));
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  // Radii as software would set them: 0.55R and 1.2R with R = min(w,h)/2.
  function automatic void std_radii(input int unsigned w, input int unsigned h,
                                    output logic [RadW-1:0] inner,
                                    output logic [RadW-1:0] outer,
                                    output logic [ScaleW-1:0] scale);
    real             rad, ri, ro;
    longint unsigned isq, osq, recip;
    rad = ((w < h) ? w : h) / 2.0;
    ri  = 0.55 * rad;
    ro  = 1.2 * rad;
    isq = longint'($floor(ri * ri));
    osq = longint'($floor(ro * ro));
    if (isq > 24'hFFFFFF) isq = 24'hFFFFFF;
    if (osq > 24'hFFFFFF) osq = 24'hFFFFFF;
    recip = (osq > isq) ? (64'd1 << 32) / (osq - isq) : 0;
    if (recip > 32'hFFFFFFFF) recip = 32'hFFFFFFFF;
    inner = RadW'(isq);
    outer = RadW'(osq);
    scale = ScaleW'(recip);
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 4095;
      4:       return 4096;
      5:       return 4097;
      6:       return 8191;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // Saturated and checkered pixels, or random ones.
  function automatic logic [PixW-1:0] pick_pixel(input bit fixed, input int unsigned k);
    logic [PixW-1:0] px;
    px = PixW'($urandom);
    if (fixed || $urandom_range(99) < 15) begin
      case (k % 8)
        0:       px = 24'h000000;
        1:       px = 24'hFFFFFF;
        2:       px = 24'h0000FF;
        3:       px = 24'h00FF00;
        4:       px = 24'hFF0000;
        5:       px = 24'h55AA55;
        6:       px = 24'hAA55AA;
        default: px = 24'h808080;
      endcase
    end
    return px;
  endfunction

  // Offer one pixel, with random gaps outside the quiet window, and wait for
  // the request to be taken.
  task automatic send_pixel(input logic [PixW-1:0] px);
    if (items_sent < 800 || items_sent >= 1100) begin
      while ($urandom_range(99) < 23) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send a run of pixels, then let the pipeline empty before any register write.
  // The extra edge lets the monitor note the last accepted request first.
  task automatic stream_pixels(input int unsigned n, input bit fixed);
    for (int unsigned k = 0; k < n; k++) send_pixel(pick_pixel(fixed, k));
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.faded_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // A random configuration followed by a run; small frames wrap several times.
  task automatic random_phase(input int unsigned n_first);
    int unsigned       sel, w, h, n;
    logic [RadW-1:0]   inner, outer;
    logic [ScaleW-1:0] scale;
    sel = $urandom_range(99);
    w = $urandom_range(1, 40);
    h = $urandom_range(1, 24);
    if (sel >= 85 && sel < 93) begin
      w = pick_dim();
      h = pick_dim();
    end
    std_radii(w, h, inner, outer, scale);
    if (sel >= 70 && sel < 85) begin
      inner = RadW'($urandom_range(0, 700));
      outer = RadW'($urandom_range(0, 900));
      case ($urandom_range(3))
        0:       scale = '0;
        1:       scale = '1;
        2:       scale = ScaleW'($urandom);
        default: ;
      endcase
    end else if (sel >= 93) begin
      inner = RadW'($urandom);
      outer = $urandom_range(1) ? '1 : RadW'($urandom);
      scale = ScaleW'($urandom);
    end
    configure(DimW'(w), DimW'(h), inner, outer, scale);
    if (n_first != 0) begin
      n = n_first;
    end else if (w <= 64 && h <= 64) begin
      n = w * h * $urandom_range(1, 3);
      if (n > 300) n = 300;
      if (n < 8) n = 8;
    end else begin
      n = $urandom_range(20, 120);
    end
    // Keep the total close to the planned number of pixels.
    if (n > TotalPixels - items_sent) n = TotalPixels - items_sent;
    stream_pixels(n, 1'b0);
  endtask

  initial begin : stimulus
    logic [RadW-1:0]   inner, outer;
    logic [ScaleW-1:0] scale;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset.
    stream_pixels(3, 1'b1);
    // Zero width and height act as a one-pixel frame.
    configure('0, '0, '0, '0, '0);
    stream_pixels(2, 1'b1);
    // Small frame crossing pass, fade and black.
    configure(13'd8, 13'd4, 24'd1, 24'd5, 32'h4000_0000);
    stream_pixels(6, 1'b1);
    // Width shrunk while the column counter is already past it.
    configure(13'd2, 13'd4, 24'd1, 24'd5, 32'h4000_0000);
    stream_pixels(3, 1'b1);
    // Inner radius above the outer one: no fade band.
    configure(13'd6, 13'd3, 24'd20, 24'd5, 32'h0001_0000);
    stream_pixels(4, 1'b1);
    // Scale so large that the fade saturates past one.
    configure(13'd6, 13'd3, 24'd0, 24'd100, 32'hFFFF_FFFF);
    stream_pixels(4, 1'b1);
    // Oversized dimensions clamp to the largest frame.
    std_radii(8191, 4096, inner, outer, scale);
    configure(13'h1FFF, 13'd4096, inner, outer, scale);
    stream_pixels(3, 1'b1);

    // Random part; the first run is long enough to span a receiver hold-off.
    random_phase(400);
    while (items_sent < TotalPixels) random_phase(0);

    if (sb.faded_q.size() != 0)
      sb.report($sformatf("%0d faded pixels never came out", sb.faded_q.size()));
    $display("Streamed %0d pixels over %0d configurations, %0d frame ends, %0d outputs.",
             items_sent, n_configs, sb.n_frames, sb.n_results);
    $display("Predicted pass / fade / black: %0d / %0d / %0d.",
             sb.n_pass, sb.n_fade, sb.n_black);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
